FILE: sv/ptms_pkg.sv
// Shared types and constants for the pulse test mode sequencer.
package ptms_pkg;

  localparam int unsigned TimeW      = 64;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CodeW      = 16;
  localparam int unsigned VoltW      = 16;
  localparam logic [CfgW-1:0] SettleDefaultMs = 16'd50;

  typedef enum logic [2:0] {
    CMD_TICK          = 3'd0,
    CMD_ENABLE_POWER  = 3'd1,
    CMD_DISABLE_POWER = 3'd2,
    CMD_START         = 3'd3,
    CMD_STOP          = 3'd4,
    CMD_CLEAR_FAULT   = 3'd5,
    CMD_CLEAR_WARNING = 3'd6,
    CMD_PULSE_END     = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    DEV_NONE  = 2'd0,
    DEV_FAULT = 2'd1,
    DEV_READY = 2'd2,
    DEV_PROC  = 2'd3
  } dev_state_t;

  typedef enum logic [2:0] {
    SUB_NONE       = 3'd0,
    SUB_WAIT       = 3'd1,
    SUB_SUPPLY_OFF = 3'd2,
    SUB_START      = 3'd3,
    SUB_PULSE      = 3'd4,
    SUB_SUPPLY_ON  = 3'd5
  } sub_state_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_BLOCKED   = 2'd1,
    ERR_NOT_READY = 2'd2
  } user_err_t;

  localparam logic [CfgIdxW-1:0] CFG_PAUSE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE = 2'd1;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_t             command;
    logic [CodeW-1:0] pulse_fault_code;
    logic [VoltW-1:0] measured_voltage;
  } item_t;

  typedef struct packed {
    dev_state_t       device_state;
    sub_state_t       sub_state;
    user_err_t        user_error;
    logic             supply_enabled;
    logic             pulse_begin;
    logic [CodeW-1:0] fault_reason;
    logic [VoltW-1:0] result_voltage;
    logic             op_result;
    logic             warning_flag;
  } result_t;

endpackage

FILE: sv/ptms_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ptms_in_if
  import ptms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       command;
  logic [CodeW-1:0] pulse_fault_code;
  logic [VoltW-1:0] measured_voltage;

  modport source (output valid, command, pulse_fault_code, measured_voltage, input ready);
  modport sink   (input valid, command, pulse_fault_code, measured_voltage, output ready);
endinterface

interface ptms_out_if
  import ptms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       device_state;
  logic [2:0]       sub_state;
  logic [1:0]       user_error;
  logic             supply_enabled;
  logic             pulse_begin;
  logic [CodeW-1:0] fault_reason;
  logic [VoltW-1:0] result_voltage;
  logic             op_result;
  logic             warning_flag;

  modport source (output valid, device_state, sub_state, user_error, supply_enabled,
                  pulse_begin, fault_reason, result_voltage, op_result, warning_flag,
                  input ready);
  modport sink   (input valid, device_state, sub_state, user_error, supply_enabled,
                  pulse_begin, fault_reason, result_voltage, op_result, warning_flag,
                  output ready);
endinterface

FILE: sv/ptms_in_stage.sv
// Input register that captures one beat from the input channel.
module ptms_in_stage
  import ptms_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  ptms_in_if.sink in_ch,
  input  logic  take,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.command          <= cmd_t'(in_ch.command);
      item_r.pulse_fault_code <= in_ch.pulse_fault_code;
      item_r.measured_voltage <= in_ch.measured_voltage;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: sv/ptms_core.sv
// Device state, timers, configuration and the per-item update rules.
module ptms_core
  import ptms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  dev_state_t       dev_r, dev_nxt;
  sub_state_t       sub_r, sub_nxt;
  logic [TimeW-1:0] time_r, time_nxt;
  logic [TimeW-1:0] tnext_r, tnext_nxt;
  logic [TimeW-1:0] pause_dl_r, pause_dl_nxt;
  logic [TimeW-1:0] settle_dl_r, settle_dl_nxt;
  logic             supply_r, supply_nxt;
  logic [CodeW-1:0] fault_r, fault_nxt;
  logic [VoltW-1:0] result_r, result_nxt;
  logic             op_ok_r, op_ok_nxt;
  logic [CfgW-1:0]  pause_cfg_r;
  logic [CfgW-1:0]  settle_cfg_r;

  logic [TimeW-1:0] settle_arm;
  logic             settle_hit;
  user_err_t        err;
  logic             begin_pulse;

  assign settle_arm = tnext_r + TimeW'(settle_cfg_r);
  assign settle_hit = (settle_dl_r != '0) && (tnext_r >= settle_dl_r);

  always_comb begin
    dev_nxt       = dev_r;
    sub_nxt       = sub_r;
    time_nxt      = time_r;
    tnext_nxt     = tnext_r;
    pause_dl_nxt  = pause_dl_r;
    settle_dl_nxt = settle_dl_r;
    supply_nxt    = supply_r;
    fault_nxt     = fault_r;
    result_nxt    = result_r;
    op_ok_nxt     = op_ok_r;
    err           = ERR_OK;
    begin_pulse   = 1'b0;
    case (item.command)
      CMD_TICK: begin
        time_nxt  = tnext_r;
        tnext_nxt = tnext_r + TimeW'(1);
        if (dev_r == DEV_PROC) begin
          case (sub_r)
            SUB_WAIT: begin
              if (tnext_r > pause_dl_r) begin
                sub_nxt = SUB_SUPPLY_OFF;
              end
            end
            SUB_SUPPLY_OFF: begin
              if (settle_dl_r == '0) begin
                settle_dl_nxt = settle_arm;
                supply_nxt    = 1'b0;
              end else if (settle_hit) begin
                settle_dl_nxt = '0;
                sub_nxt       = SUB_START;
              end else begin
                supply_nxt = 1'b0;
              end
            end
            SUB_START: begin
              sub_nxt     = SUB_PULSE;
              begin_pulse = 1'b1;
            end
            SUB_SUPPLY_ON: begin
              if (settle_dl_r == '0) begin
                settle_dl_nxt = settle_arm;
              end else if (settle_hit) begin
                settle_dl_nxt = '0;
                supply_nxt    = 1'b1;
                dev_nxt       = DEV_READY;
                sub_nxt       = SUB_NONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CMD_ENABLE_POWER: begin
        if (dev_r == DEV_NONE) begin
          supply_nxt = 1'b1;
          dev_nxt    = DEV_READY;
          sub_nxt    = SUB_NONE;
        end else if (dev_r != DEV_READY) begin
          err = ERR_BLOCKED;
        end
      end
      CMD_DISABLE_POWER: begin
        if (dev_r == DEV_READY) begin
          supply_nxt = 1'b0;
          dev_nxt    = DEV_NONE;
          sub_nxt    = SUB_NONE;
        end else if (dev_r != DEV_NONE) begin
          err = ERR_BLOCKED;
        end
      end
      CMD_START: begin
        if (dev_r == DEV_READY) begin
          fault_nxt  = '0;
          result_nxt = '0;
          op_ok_nxt  = 1'b0;
          dev_nxt    = DEV_PROC;
          sub_nxt    = SUB_WAIT;
        end else if (dev_r == DEV_PROC) begin
          err = ERR_BLOCKED;
        end else begin
          err = ERR_NOT_READY;
        end
      end
      CMD_STOP: begin
        if (dev_r == DEV_PROC) begin
          dev_nxt = DEV_READY;
          sub_nxt = SUB_NONE;
        end
      end
      CMD_CLEAR_FAULT: begin
        if (dev_r == DEV_FAULT) begin
          dev_nxt   = DEV_NONE;
          sub_nxt   = SUB_NONE;
          fault_nxt = '0;
        end
      end
      CMD_CLEAR_WARNING: begin
      end
      CMD_PULSE_END: begin
        if (sub_r == SUB_PULSE) begin
          pause_dl_nxt = time_r + TimeW'(pause_cfg_r);
          if (item.pulse_fault_code != '0) begin
            dev_nxt   = DEV_FAULT;
            sub_nxt   = SUB_NONE;
            fault_nxt = item.pulse_fault_code;
          end else begin
            result_nxt = item.measured_voltage;
            op_ok_nxt  = 1'b1;
            dev_nxt    = DEV_PROC;
            sub_nxt    = SUB_SUPPLY_ON;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r       <= DEV_NONE;
      sub_r       <= SUB_NONE;
      time_r      <= '0;
      tnext_r     <= TimeW'(1);
      pause_dl_r  <= '0;
      settle_dl_r <= '0;
      supply_r    <= 1'b0;
      fault_r     <= '0;
      result_r    <= '0;
      op_ok_r     <= 1'b0;
    end else if (fire) begin
      dev_r       <= dev_nxt;
      sub_r       <= sub_nxt;
      time_r      <= time_nxt;
      tnext_r     <= tnext_nxt;
      pause_dl_r  <= pause_dl_nxt;
      settle_dl_r <= settle_dl_nxt;
      supply_r    <= supply_nxt;
      fault_r     <= fault_nxt;
      result_r    <= result_nxt;
      op_ok_r     <= op_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_cfg_r  <= '0;
      settle_cfg_r <= SettleDefaultMs;
    end else if (cfg.we) begin
      if (cfg.index == CFG_PAUSE) begin
        pause_cfg_r <= cfg.data;
      end else if (cfg.index == CFG_SETTLE) begin
        settle_cfg_r <= cfg.data;
      end
    end
  end

  always_comb begin
    res.device_state   = dev_nxt;
    res.sub_state      = sub_nxt;
    res.user_error     = err;
    res.supply_enabled = supply_nxt;
    res.pulse_begin    = begin_pulse;
    res.fault_reason   = fault_nxt;
    res.result_voltage = result_nxt;
    res.op_result      = op_ok_nxt;
    res.warning_flag   = 1'b0;
  end

  a_idle_sub_none: assert property (@(posedge clk) disable iff (!rst_n)
    (dev_r != DEV_PROC) |-> (sub_r == SUB_NONE))
    else $error("Substate is active outside the in-process state.");

  a_tnext_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    tnext_r == time_r + TimeW'(1))
    else $error("Next-time register lost track of the time counter.");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.command == CMD_TICK) |=> (time_r == $past(time_r) + TimeW'(1)))
    else $error("Tick did not advance the time counter by one.");

  a_begin_enters_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.pulse_begin) |=> (dev_r == DEV_PROC && sub_r == SUB_PULSE))
    else $error("Pulse start did not enter the pulse substate.");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.user_error != ERR_OK) |=> (dev_r == $past(dev_r) && sub_r == $past(sub_r)))
    else $error("Refused command changed the device state.");

endmodule

FILE: sv/ptms_out_stage.sv
// Result register that holds one beat for the output channel.
module ptms_out_stage
  import ptms_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  ptms_out_if.source out_ch
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.device_state   = res_r.device_state;
  assign out_ch.sub_state      = res_r.sub_state;
  assign out_ch.user_error     = res_r.user_error;
  assign out_ch.supply_enabled = res_r.supply_enabled;
  assign out_ch.pulse_begin    = res_r.pulse_begin;
  assign out_ch.fault_reason   = res_r.fault_reason;
  assign out_ch.result_voltage = res_r.result_voltage;
  assign out_ch.op_result      = res_r.op_result;
  assign out_ch.warning_flag   = res_r.warning_flag;

endmodule

FILE: sv/pulse_test_mode_sequencer.sv
// Top level of the pulse test mode sequencer.
// A beat accepted is held in the input register; its result is then registered in
// the result register. Throughput: one beat per cycle while the result channel is
// ready; the state update between the two is a single 64-bit add and compare deep.
// Reset (rst_n low, synchronous) empties both registers, returns the device to
// none with the time counter and deadlines at zero, and loads the settle delay with 50 ms.
module pulse_test_mode_sequencer
  import ptms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  ptms_in_if.sink            in_ch,
  ptms_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  logic    item_valid;
  item_t   item;
  logic    can_load;
  logic    fire;
  result_t res;
  cfg_wr_t cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;
  assign fire      = item_valid && can_load;

  ptms_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (can_load),
    .item_valid (item_valid),
    .item       (item)
  );

  ptms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  ptms_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (item_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
